// ===== rtl/pip_pkg.sv =====
// Package for the point-in-polygon test block.
// Holds word types, operation codes, sizes and the controller/datapath link structs.
// No dependencies.
`default_nettype none
package pip_pkg;

  localparam int unsigned CoordWidth  = 16;
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned AddrWidth   = $clog2(MaxVertices);
  localparam int unsigned CountWidth  = $clog2(MaxVertices + 1);
  localparam int unsigned DiffWidth   = CoordWidth + 1;
  localparam int unsigned ProdWidth   = 2 * CoordWidth;
  localparam int unsigned DivSteps    = CoordWidth;
  localparam int unsigned StepWidth   = $clog2(DivSteps);

  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpAppend = 2'd1,
    OpQuery  = 2'd2,
    OpUnused = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
  } in_word_t;

  typedef struct packed {
    logic                  inside_res;
    logic                  status;
    logic [CountWidth-1:0] vertex_count;
  } out_word_t;

  typedef struct packed {
    logic                 capture;
    logic                 clear;
    logic                 append;
    logic                 rd;
    logic [AddrWidth-1:0] rd_addr;
    logic                 latch_j;
    logic                 latch_i;
    logic                 mul;
    logic                 prep;
    logic                 div;
    logic                 cmp;
    logic                 advance;
  } cmd_t;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic                  full;
    logic                  empty;
    logic                  straddle;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/point_in_polygon_test.sv =====
// Top level of the point-in-polygon test: controller plus datapath.
// Depends on pip_pkg, pip_ctrl and pip_dp.
//
//   channel | direction | handshake                | word
//   in      | input     | in_valid_i / in_ready_o  | in_word_i  (pip_pkg::in_word_t)
//   out     | output    | out_valid_o / out_ready_i| out_word_o (pip_pkg::out_word_t)
//
// Clear, append and unused words pass from idle through the done state to a result.
// A query on a non-empty list walks each edge; an edge that crosses the point's y
// also passes through the multiply, prep, 16-step restoring divider and compare states.
// Reset empties the vertex list; the vertex memory itself is not cleared.
// A new word is taken only while the controller is idle, once the previous result is taken or leaves in that cycle.
`default_nettype none
module point_in_polygon_test (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pip_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pip_pkg::out_word_t     out_word_o
);
  import pip_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_word_i.operation),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pip_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= CountWidth'(MaxVertices))
    else $error("vertex count above capacity");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status |-> sts.full)
    else $error("drop flagged while store not full");

  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result shown too early after accept");
`endif

endmodule
`default_nettype wire

// ===== rtl/pip_dp.sv =====
// Datapath of the point-in-polygon test: vertex memory, edge registers,
// multiplier, restoring divider and crossing compare. Depends on pip_pkg.
`default_nettype none
module pip_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pip_pkg::in_word_t in_word_i,
  input  wire pip_pkg::cmd_t     cmd_i,
  output pip_pkg::sts_t          sts_o,
  output pip_pkg::out_word_t     out_word_o
);
  import pip_pkg::*;

  logic [CoordWidth-1:0] mem_x [MaxVertices];
  logic [CoordWidth-1:0] mem_y [MaxVertices];
  logic [CoordWidth-1:0] rd_x_q, rd_y_q;

  logic [CountWidth-1:0] count_q;
  logic                  inside_q, status_q;
  logic signed [CoordWidth-1:0] px_q, py_q, xi_q, yi_q, xj_q, yj_q;
  logic [ProdWidth-1:0]  prod_q;
  logic [CoordWidth-1:0] dmag_q, rem_q, quo_q;
  logic                  neg_q;

  logic signed [DiffWidth-1:0] a_s, b_s, d_s;
  logic [DiffWidth-1:0]  a_m, b_m, d_m;
  logic [DiffWidth-1:0]  trial;
  logic                  fits;
  logic signed [DiffWidth:0] cx;
  logic                  full;

  assign full = (count_q == CountWidth'(MaxVertices));

  assign a_s = DiffWidth'(xj_q) - DiffWidth'(xi_q);
  assign b_s = DiffWidth'(py_q) - DiffWidth'(yi_q);
  assign d_s = DiffWidth'(yj_q) - DiffWidth'(yi_q);
  assign a_m = a_s[DiffWidth-1] ? DiffWidth'(-a_s) : DiffWidth'(a_s);
  assign b_m = b_s[DiffWidth-1] ? DiffWidth'(-b_s) : DiffWidth'(b_s);
  assign d_m = d_s[DiffWidth-1] ? DiffWidth'(-d_s) : DiffWidth'(d_s);

  assign trial = {rem_q, quo_q[CoordWidth-1]};
  assign fits  = (trial >= {1'b0, dmag_q});

  assign cx = (DiffWidth+1)'(xi_q) +
              (neg_q ? -(DiffWidth+1)'({2'b00, quo_q}) : (DiffWidth+1)'({2'b00, quo_q}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem_x[count_q[AddrWidth-1:0]] <= in_word_i.x;
      mem_y[count_q[AddrWidth-1:0]] <= in_word_i.y;
    end
    if (cmd_i.rd) begin
      rd_x_q <= mem_x[cmd_i.rd_addr];
      rd_y_q <= mem_y[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      inside_q <= 1'b0;
      status_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        inside_q <= 1'b0;
        status_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end
      if (cmd_i.append) begin
        if (full) begin
          status_q <= 1'b1;
        end else begin
          count_q <= count_q + CountWidth'(1);
        end
      end
      if (cmd_i.cmp && ($signed({px_q[CoordWidth-1], px_q[CoordWidth-1], px_q}) < cx)) begin
        inside_q <= !inside_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q <= in_word_i.x;
      py_q <= in_word_i.y;
    end
    if (cmd_i.latch_j) begin
      xj_q <= rd_x_q;
      yj_q <= rd_y_q;
    end
    if (cmd_i.latch_i) begin
      xi_q <= rd_x_q;
      yi_q <= rd_y_q;
    end
    if (cmd_i.advance) begin
      xj_q <= xi_q;
      yj_q <= yi_q;
    end
    if (cmd_i.mul) begin
      prod_q <= a_m[CoordWidth-1:0] * b_m[CoordWidth-1:0];
      dmag_q <= d_m[CoordWidth-1:0];
      neg_q  <= a_s[DiffWidth-1] ^ b_s[DiffWidth-1] ^ d_s[DiffWidth-1];
    end
    if (cmd_i.prep) begin
      rem_q <= prod_q[ProdWidth-1:CoordWidth];
      quo_q <= prod_q[CoordWidth-1:0];
    end
    if (cmd_i.div) begin
      rem_q <= fits ? CoordWidth'(trial - {1'b0, dmag_q}) : trial[CoordWidth-1:0];
      quo_q <= {quo_q[CoordWidth-2:0], fits};
    end
  end

  assign sts_o.count    = count_q;
  assign sts_o.full     = full;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.straddle = (yi_q > py_q) != (yj_q > py_q);

  assign out_word_o.inside_res   = inside_q;
  assign out_word_o.status       = status_q;
  assign out_word_o.vertex_count = count_q;

endmodule
`default_nettype wire

// ===== rtl/pip_ctrl.sv =====
// Controller of the point-in-polygon test: decodes each word and sequences
// the edge walk and the divider. Depends on pip_pkg.
`default_nettype none
module pip_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_op_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire pip_pkg::sts_t sts_i,
  output pip_pkg::cmd_t      cmd_o
);
  import pip_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_J    = 3'd1;
  localparam logic [2:0] S_I    = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_PREP = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [AddrWidth-1:0]  idx_q, idx_d;
  logic [StepWidth-1:0]  step_q, step_d;
  logic                  out_valid_q, out_valid_d;
  logic [CountWidth-1:0] cnt_m1;
  logic [AddrWidth-1:0]  last;
  logic                  accept;

  assign cnt_m1     = sts_i.count - CountWidth'(1);
  assign last       = cnt_m1[AddrWidth-1:0];
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    idx_d       = idx_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DONE;
          case (op_e'(in_op_i))
            OpClear:  cmd_o.clear  = 1'b1;
            OpAppend: cmd_o.append = 1'b1;
            OpQuery: begin
              if (!sts_i.empty) begin
                cmd_o.rd      = 1'b1;
                cmd_o.rd_addr = last;
                state_d       = S_J;
              end
            end
            default: ;
          endcase
        end
      end
      S_J: begin
        cmd_o.latch_j = 1'b1;
        cmd_o.rd      = 1'b1;
        cmd_o.rd_addr = '0;
        idx_d         = '0;
        state_d       = S_I;
      end
      S_I: begin
        cmd_o.latch_i = 1'b1;
        state_d       = S_MUL;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        step_d    = step_q + StepWidth'(1);
        if (step_q == StepWidth'(DivSteps - 1)) begin
          state_d = S_CMP;
        end
      end
      S_MUL, S_CMP: begin
        if (state_q == S_MUL && sts_i.straddle) begin
          cmd_o.mul = 1'b1;
          state_d   = S_PREP;
        end else begin
          cmd_o.cmp     = (state_q == S_CMP);
          cmd_o.advance = 1'b1;
          if (idx_q == last) begin
            state_d = S_DONE;
          end else begin
            idx_d         = idx_q + AddrWidth'(1);
            cmd_o.rd      = 1'b1;
            cmd_o.rd_addr = idx_q + AddrWidth'(1);
            state_d       = S_I;
          end
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== dv/point_in_polygon_test_tb.sv =====
// Testbench for the point-in-polygon test block: a directed table, an overfill
// of the vertex store, then random polygons and queries, all checked against a
// crossing-number predictor. Depends on pip_pkg and point_in_polygon_test.
`timescale 1ns / 1ps
module point_in_polygon_test_tb;
  import pip_pkg::*;

  localparam int CycleLimit = 20000000;

  typedef struct {
    op_e             op;
    int              x;
    int              y;
    bit              known;
    bit              in_res;
    bit              status;
    int              count;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  int        poly_x[MaxVertices];
  int        poly_y[MaxVertices];
  int        poly_count = 0;
  out_word_t expected_q[$];
  int        errors = 0;
  int        cycle_count = 0;
  bit        calm = 1'b0;
  bit        stim_done = 1'b0;

  point_in_polygon_test dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .out_valid_o, .out_ready_i, .out_word_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("point_in_polygon_test: mismatch");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("error at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic longint trunc_div(longint a, longint b, longint d);
    longint m;
    bit neg;
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) / (d < 0 ? -d : d);
    neg = ((a < 0) != (b < 0)) != (d < 0);
    return neg ? -m : m;
  endfunction

  function automatic bit point_inside(int px, int py);
    bit in_flag;
    int j;
    longint cx;
    in_flag = 1'b0;
    if (poly_count == 0) return 1'b0;
    j = poly_count - 1;
    for (int i = 0; i < poly_count; i++) begin
      if ((poly_y[i] > py) != (poly_y[j] > py)) begin
        cx = trunc_div(poly_x[j] - poly_x[i], py - poly_y[i], poly_y[j] - poly_y[i]) + poly_x[i];
        if (px < cx) in_flag = ~in_flag;
      end
      j = i;
    end
    return in_flag;
  endfunction

  function automatic out_word_t predict_word(op_e op, int x, int y);
    out_word_t w;
    w = '0;
    case (op)
      OpClear: poly_count = 0;
      OpAppend: begin
        if (poly_count < MaxVertices) begin
          poly_x[poly_count] = x;
          poly_y[poly_count] = y;
          poly_count++;
        end else begin
          w.status = 1'b1;
        end
      end
      OpQuery: w.inside_res = point_inside(x, y);
      default: ;
    endcase
    w.vertex_count = CountWidth'(poly_count);
    return w;
  endfunction

  task automatic send_word(op_e op, int x, int y);
    while (!calm && $urandom_range(99) < 20) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_word_i = '{operation: op, x: x[15:0], y: y[15:0]};
    expected_q.insert(expected_q.size(), predict_word(op, x, y));
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        exp_w = expected_q.pop_front();
        if (out_word_o.inside_res !== exp_w.inside_res)
          report($sformatf("inside_res %b, expected %b", out_word_o.inside_res,
                           exp_w.inside_res));
        if (out_word_o.status !== exp_w.status)
          report($sformatf("status %b, expected %b", out_word_o.status, exp_w.status));
        if (out_word_o.vertex_count !== exp_w.vertex_count)
          report($sformatf("vertex_count %0d, expected %0d", out_word_o.vertex_count,
                           exp_w.vertex_count));
      end
    end
  end

  function automatic int rand_coord(bit narrow);
    if (narrow) return $urandom_range(200) - 100;
    return $signed(16'($urandom));
  endfunction

  stim_row_t directed[] = '{
    '{OpQuery,  0, 0, 1, 0, 0, 0},
    '{OpUnused, -32768, 32767, 1, 0, 0, 0},
    '{OpAppend, -32768, -32768, 1, 0, 0, 1},
    '{OpQuery,  0, 0, 1, 0, 0, 1},
    '{OpAppend, 32767, 32767, 1, 0, 0, 2},
    '{OpQuery,  0, 0, 1, 0, 0, 2},
    '{OpAppend, 32767, -32768, 1, 0, 0, 3},
    '{OpQuery,  30000, -100, 0, 0, 0, 0},
    '{OpQuery,  -32768, 0, 0, 0, 0, 0},
    '{OpQuery,  32767, 32767, 0, 0, 0, 0},
    '{OpQuery,  32767, -32768, 0, 0, 0, 0},
    '{OpUnused, 5, 5, 1, 0, 0, 3},
    '{OpClear,  0, 0, 1, 0, 0, 0},
    '{OpAppend, -10, -10, 1, 0, 0, 1},
    '{OpAppend, 10, -10, 1, 0, 0, 2},
    '{OpAppend, 10, 10, 1, 0, 0, 3},
    '{OpAppend, -10, 10, 1, 0, 0, 4},
    '{OpQuery,  0, 0, 0, 0, 0, 0},
    '{OpQuery,  -10, 0, 0, 0, 0, 0},
    '{OpQuery,  10, 10, 0, 0, 0, 0},
    '{OpQuery,  20, 0, 0, 0, 0, 0},
    '{OpClear,  0, 0, 1, 0, 0, 0}
  };

  initial begin
    int sent;
    int n;
    bit narrow;
    out_word_t typed;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed[k]) begin
      if (directed[k].known) begin
        typed = '{inside_res: directed[k].in_res, status: directed[k].status,
                  vertex_count: CountWidth'(directed[k].count)};
        send_word(directed[k].op, directed[k].x, directed[k].y);
        if (expected_q.size() > 0 && expected_q[$] != typed)
          report($sformatf("table row %0d disagrees with prediction", k));
      end else begin
        send_word(directed[k].op, directed[k].x, directed[k].y);
      end
    end
    for (int k = 0; k < MaxVertices + 2; k++)
      send_word(OpAppend, rand_coord(1'b0), rand_coord(1'b0));
    send_word(OpQuery, 0, 0);
    send_word(OpQuery, -32768, -32768);
    sent = 0;
    while (sent < 1500) begin
      calm = (sent >= 600 && sent < 800);
      n = ($urandom_range(9) == 0) ? $urandom_range(MaxVertices + 3, 3)
                                   : $urandom_range(8, 1);
      narrow = $urandom_range(1);
      send_word(OpClear, rand_coord(1'b0), rand_coord(1'b0));
      for (int k = 0; k < n; k++)
        send_word(OpAppend, rand_coord(narrow), rand_coord(narrow));
      for (int k = 0; k < 4; k++)
        send_word(OpQuery, rand_coord(narrow), rand_coord(narrow));
      if ($urandom_range(7) == 0)
        send_word(op_e'($urandom_range(3)), rand_coord(1'b0), rand_coord(1'b0));
      sent += n + 6;
    end
    calm = 1'b0;
    while (expected_q.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("point_in_polygon_test: match");
    end else begin
      $display("point_in_polygon_test: mismatch");
    end
    $finish;
  end

endmodule
